>>> sv/kwm_pkg.sv
// Shared constants, types and the helper function of the k-way merge selector.
package kwm_pkg;

    localparam int WAYS     = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int CFG_W    = 4;
    localparam int PAIRS    = WAYS / 2;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;
    localparam int CAP      = (WAYS < 8) ? WAYS : 8;

    localparam logic [CFG_W-1:0] NUM_WAYS_RST = CFG_W'(8);

    // One record as it travels from the front end to the merge engine.
    typedef struct packed {
        logic [IDX_W-1:0]        source;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic                    run_ended;
    } t_item;

    // Winner of one pair in the first level of the compare tree.
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
    } t_cand;

    typedef enum logic [1:0] {
        B_IDLE,
        B_TREE,
        B_FINAL
    } t_bstate;

    // Saturates the register value into the range of usable sources.
    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        n = CNT_W'(cfg);
        if (n == '0) begin
            n = CNT_W'(1);
        end else if (n > CNT_W'(CAP)) begin
            n = CNT_W'(CAP);
        end
        return n;
    endfunction

endpackage

>>> sv/kwm_front.sv
// Front end: takes input beats, drops those from inactive sources, queues the rest.
module kwm_front
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_active,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [IDX_W-1:0]        i_source,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0]        i_payload,
    input  logic                    i_run_ended,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_item                   o_item
);

    logic w_in_range;

    // A source at or above the active count can never matter, so it is discarded here.
    assign w_in_range = ({1'b0, i_source} < i_active);
    assign o_ready    = !i_q_full;
    assign o_push     = i_valid && !i_q_full && w_in_range;

    always_comb begin
        o_item.source    = i_source;
        o_item.key       = i_key;
        o_item.payload   = i_payload;
        o_item.run_ended = i_run_ended;
    end

    // The clock and reset are kept for the checks below.
    a_no_push_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ({1'b0, i_source} < i_active))
        else $error("out-of-range source pushed into the queue");

endmodule

>>> sv/kwm_queue.sv
// Two-entry queue between the front end and the merge engine.
module kwm_queue
    import kwm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

endmodule

>>> sv/kwm_back.sv
// Merge engine: keeps the head records, runs the minimum search and holds the result.
module kwm_back
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_active,
    input  logic                    i_q_valid,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [KEY_W-1:0] o_key,
    output logic [PAY_W-1:0]        o_payload,
    output logic [IDX_W-1:0]        o_source,
    output logic                    o_done
);

    t_bstate                 r_state;
    t_bstate                 n_state;
    logic signed [KEY_W-1:0] r_head_key [WAYS];
    logic [PAY_W-1:0]        r_head_pay [WAYS];
    logic [WAYS-1:0]         r_exh;
    logic [WAYS-1:0]         r_loaded;
    logic [IDX_W-1:0]        r_awaited;
    logic                    r_awaiting;
    logic                    r_finished;
    t_cand                   r_l1 [PAIRS];
    t_cand                   n_l1 [PAIRS];
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic [PAY_W-1:0]        r_out_pay;
    logic [IDX_W-1:0]        r_out_src;
    logic                    r_out_done;

    logic [WAYS-1:0]         w_act_mask;
    logic [WAYS-1:0]         w_cand;
    logic [WAYS-1:0]         w_src_hot;
    logic                    w_all_loaded;
    logic                    w_store;
    logic                    w_emit;
    logic                    w_best_valid;
    logic [IDX_W-1:0]        w_best_idx;
    logic signed [KEY_W-1:0] w_best_key;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_act_mask[i] = (CNT_W'(i) < i_active);
            w_cand[i]     = w_act_mask[i] && r_loaded[i] && !r_exh[i];
        end
    end

    assign w_src_hot    = WAYS'(1) << i_q_item.source;
    assign w_all_loaded = &(r_loaded | w_src_hot | ~w_act_mask);

    // First tree level: pairwise winners, the lower index keeps ties.
    always_comb begin
        for (int p = 0; p < PAIRS; p++) begin
            if (w_cand[2*p+1] && (!w_cand[2*p]
                    || (r_head_key[2*p+1] < r_head_key[2*p]))) begin
                n_l1[p].idx = IDX_W'(2*p+1);
                n_l1[p].key = r_head_key[2*p+1];
            end else begin
                n_l1[p].idx = IDX_W'(2*p);
                n_l1[p].key = r_head_key[2*p];
            end
            n_l1[p].valid = w_cand[2*p] || w_cand[2*p+1];
        end
    end

    // Second level over the registered pair winners, scanned in index order.
    always_comb begin
        w_best_valid = 1'b0;
        w_best_idx   = '0;
        w_best_key   = '0;
        for (int p = 0; p < PAIRS; p++) begin
            if (r_l1[p].valid && (!w_best_valid || (r_l1[p].key < w_best_key))) begin
                w_best_valid = 1'b1;
                w_best_idx   = r_l1[p].idx;
                w_best_key   = r_l1[p].key;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_store = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!r_finished) begin
                        if (r_awaiting) begin
                            if (i_q_item.source == r_awaited) begin
                                w_store = 1'b1;
                                n_state = B_TREE;
                            end
                        end else if (!r_loaded[i_q_item.source]) begin
                            w_store = 1'b1;
                            if (w_all_loaded) begin
                                n_state = B_TREE;
                            end
                        end
                    end
                end
            end
            B_TREE: begin
                n_state = B_FINAL;
            end
            B_FINAL: begin
                if (!r_out_valid || i_ready) begin
                    w_emit  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exh       <= '0;
            r_loaded    <= '0;
            r_awaited   <= '0;
            r_awaiting  <= 1'b0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_store) begin
                r_exh[i_q_item.source]    <= i_q_item.run_ended;
                r_loaded[i_q_item.source] <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                if (w_best_valid) begin
                    r_awaited  <= w_best_idx;
                    r_awaiting <= 1'b1;
                end else begin
                    r_awaiting <= 1'b0;
                    r_finished <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store && !i_q_item.run_ended) begin
            r_head_key[i_q_item.source] <= i_q_item.key;
            r_head_pay[i_q_item.source] <= i_q_item.payload;
        end
        if (r_state == B_TREE) begin
            r_l1 <= n_l1;
        end
        if (w_emit) begin
            if (w_best_valid) begin
                r_out_key  <= w_best_key;
                r_out_pay  <= r_head_pay[w_best_idx];
                r_out_src  <= w_best_idx;
                r_out_done <= 1'b0;
            end else begin
                r_out_key  <= '0;
                r_out_pay  <= '0;
                r_out_src  <= '0;
                r_out_done <= 1'b1;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_key     = r_out_key;
    assign o_payload = r_out_pay;
    assign o_source  = r_out_src;
    assign o_done    = r_out_done;

    a_done_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !r_awaiting)
        else $error("still awaiting a refill after the done result");

    a_awaited_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> r_loaded[r_awaited])
        else $error("awaited source was never loaded");

    a_winner_is_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_best_valid) |-> w_cand[w_best_idx])
        else $error("selected head is not a live candidate");

    a_tree_follows_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TREE) |-> $past(w_store))
        else $error("search started without a stored head");

endmodule

>>> sv/kwm_top_dummy_placeholder.sv
// Registered num_ways value and the active way count derived from it, shared by the front end and the merge engine.
module kwm_cfg
    import kwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic [CNT_W-1:0] o_active
);

    logic [CFG_W-1:0] r_num_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ways <= NUM_WAYS_RST;
        end else if (i_cfg_we) begin
            r_num_ways <= i_cfg_wdata;
        end
    end

    assign o_active = active_count(r_num_ways);

endmodule

>>> sv/k_way_merge_selector_unit.sv
// Top level of the k-way merge selector: register, front end, queue and merge engine.
//
//   Channel   Direction  Handshake             Fields
//   input     in         i_valid / o_ready     i_source, i_key, i_payload, i_run_ended
//   result    out        o_valid / i_ready     o_out_key, o_out_payload, o_out_source,
//                                              o_all_done
//   config    in         i_cfg_we              i_cfg_wdata (num_ways)
//
// A beat that produces a result passes through the engine's three states: the idle
// state stores the head, the tree state registers the first level of the compare
// tree and the final state selects, waiting while the previous result is untaken; a
// new search starts only back in the idle state. Beats that only load a head or are
// ignored by the engine are popped in the idle state without a search, and beats
// from inactive sources are dropped by the front end without reaching it. The front
// end keeps taking beats into the two-entry queue while it has room, and a finished
// result waits in the output register. Reset is synchronous and active low; it
// restores num_ways to eight and clears the exhaustion, loaded and control state,
// while the head records stay undefined until written. No clearing pass follows reset.
module k_way_merge_selector_unit
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [IDX_W-1:0]        i_source,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0]        i_payload,
    input  logic                    i_run_ended,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [KEY_W-1:0] o_out_key,
    output logic [PAY_W-1:0]        o_out_payload,
    output logic [IDX_W-1:0]        o_out_source,
    output logic                    o_all_done,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata
);

    logic [CNT_W-1:0] w_active;
    logic             w_q_full;
    logic             w_push;
    t_item            w_push_item;
    logic             w_q_valid;
    logic             w_q_pop;
    t_item            w_q_item;

    // The active count is saturated once here and shared by both halves.
    kwm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_active    (w_active)
    );

    // The front end accepts a beat whenever the queue has room, dropping inactive sources.
    kwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (w_active),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_source    (i_source),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .i_run_ended (i_run_ended),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    kwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // The merge engine decides whether a queued beat is stored or ignored, and emits.
    kwm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_active  (w_active),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_key     (o_out_key),
        .o_payload (o_out_payload),
        .o_source  (o_out_source),
        .o_done    (o_all_done)
    );

    // A done result, once delivered, is never followed by another result.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_all_done) |=> !o_valid)
        else $error("result emitted after the done beat");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the k-way merge selector: directed and random merge traffic.
module tb_top
    import kwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The block caps the active run count at eight, or at WAYS if that is smaller.
    localparam int WAY_CAP       = (WAYS < 8) ? WAYS : 8;
    localparam int RANDOM_BEATS  = 780;
    localparam int MAX_GAP       = 6;
    // Beats that cause no result may still sit in the two-entry queue or the engine
    // once the last expected result has arrived; this many cycles lets them drain.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_CAP    = 100;

    localparam logic [CFG_W-1:0]        WAYS_AT_RESET = CFG_W'(8);
    localparam logic signed [KEY_W-1:0] KEY_LOWEST    = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_HIGHEST   = 32'sh7fff_ffff;
    localparam logic [PAY_W-1:0]        PAY_ONES      = '1;

    // One record that the merge is expected to emit, or the closing done beat.
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [IDX_W-1:0]        source;
        logic                    done;
    } t_emitted;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [IDX_W-1:0]        i_source;
    logic signed [KEY_W-1:0] i_key;
    logic [PAY_W-1:0]        i_payload;
    logic                    i_run_ended;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [KEY_W-1:0] o_out_key;
    logic [PAY_W-1:0]        o_out_payload;
    logic [IDX_W-1:0]        o_out_source;
    logic                    o_all_done;
    logic                    i_cfg_we;
    logic [CFG_W-1:0]        i_cfg_wdata;

    k_way_merge_selector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_source      (i_source),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_run_ended   (i_run_ended),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_out_source  (o_out_source),
        .o_all_done    (o_all_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Our own copy of the merge state. It is advanced at the rising edge on which
    // an input beat is accepted, so that the stimulus can always see which run the
    // block is waiting on and which runs are still alive.
    // ------------------------------------------------------------------------
    logic signed [KEY_W-1:0] run_key [WAYS] = '{default: '0};
    logic [PAY_W-1:0]        run_payload [WAYS] = '{default: '0};
    bit [WAYS-1:0]           run_spent      = '0;
    bit [WAYS-1:0]           run_seen       = '0;
    int                      wait_src       = 0;
    bit                      refill_pending = 1'b0;
    bit                      merge_over     = 1'b0;
    logic [CFG_W-1:0]        ways_reg       = WAYS_AT_RESET;

    t_emitted emitted_due [$];

    // Bookkeeping for the summary and for the pacing of both channels.
    int mismatches   = 0;
    int beats_sent   = 0;
    int beats_used   = 0;
    int results_seen = 0;
    int done_seen    = 0;
    int cfg_writes   = 0;
    int hold_cycles  = 0;
    int cycle_count  = 0;
    bit fast_feed    = 1'b0;
    bit fast_drain   = 1'b0;

    // The register value is saturated into 1 .. WAY_CAP; zero behaves as one.
    function automatic int ways_in_use(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > WAY_CAP) n = WAY_CAP;
        return n;
    endfunction

    // Advances the merge state by one accepted beat and queues any record that
    // the block must emit for it. Returns 1 when the beat was acted on rather
    // than ignored.
    function automatic bit merge_step(input t_item it);
        int n;
        int s;
        int best;
        if (merge_over) return 1'b0;
        n = ways_in_use(ways_reg);
        s = int'(it.source);
        // Inactive runs are ignored, as is any run other than the awaited one
        // while merging, and a second first record while the heads are loading.
        if (s >= n) return 1'b0;
        if (refill_pending ? (s != wait_src) : run_seen[s]) return 1'b0;
        run_spent[s] = it.run_ended;
        if (!it.run_ended) begin
            run_key[s]     = it.key;
            run_payload[s] = it.payload;
        end
        if (!refill_pending) begin
            run_seen[s] = 1'b1;
            for (int i = 0; i < n; i++)
                if (!run_seen[i]) return 1'b1;
        end
        // Linear minimum search; the strict compare hands ties to the lower run.
        // Runs that never delivered a head are skipped, so their contents are
        // never looked at.
        best = -1;
        for (int i = 0; i < n; i++) begin
            if (run_seen[i] && !run_spent[i] && (best < 0 || run_key[i] < run_key[best]))
                best = i;
        end
        if (best < 0) begin
            emitted_due.push_back('{key: '0, payload: '0, source: '0, done: 1'b1});
            merge_over     = 1'b1;
            refill_pending = 1'b0;
        end else begin
            emitted_due.push_back('{key: run_key[best], payload: run_payload[best],
                                    source: IDX_W'(best), done: 1'b0});
            wait_src       = best;
            refill_pending = 1'b1;
        end
        return 1'b1;
    endfunction

    // Number of live heads that would remain after this beat, or -1 if the beat
    // would not trigger a selection at all. Used to keep the merge running.
    function automatic int heads_left_after(input t_item it);
        int n;
        int s;
        int left;
        bit [WAYS-1:0] seen;
        bit [WAYS-1:0] spent;
        if (merge_over) return -1;
        n = ways_in_use(ways_reg);
        s = int'(it.source);
        if (s >= n) return -1;
        if (refill_pending ? (s != wait_src) : run_seen[s]) return -1;
        seen     = run_seen;
        spent    = run_spent;
        seen[s]  = 1'b1;
        spent[s] = it.run_ended;
        left     = 0;
        for (int i = 0; i < n; i++) begin
            if (!refill_pending && !seen[i]) return -1;
            if (seen[i] && !spent[i]) left++;
        end
        return left;
    endfunction

    function automatic t_item rec(input int src, input logic signed [KEY_W-1:0] key,
                                  input logic [PAY_W-1:0] payload, input bit ended);
        t_item it;
        it.source    = IDX_W'(src);
        it.key       = key;
        it.payload   = payload;
        it.run_ended = ended;
        return it;
    endfunction

    // Mostly well-formed refills for the awaited run with random content; about a
    // fifth are noise from any run. End marks are rare, and one that would leave
    // fewer than two live runs is withdrawn so the merge keeps going until the
    // final drain.
    function automatic t_item make_record();
        t_item it;
        int left;
        it.source = refill_pending ? IDX_W'(wait_src) : IDX_W'($urandom_range(0, WAYS - 1));
        case ($urandom_range(0, 15))
            0, 1, 2, 3: it.key = $urandom_range(0, 6) - 3;
            4:          it.key = KEY_LOWEST;
            5:          it.key = KEY_HIGHEST;
            default:    it.key = $urandom;
        endcase
        it.payload   = {$urandom, $urandom};
        it.run_ended = ($urandom_range(0, 199) == 0);
        if ($urandom_range(0, 4) == 0) begin
            it.source    = IDX_W'($urandom_range(0, WAYS - 1));
            it.run_ended = ($urandom_range(0, 3) == 0);
        end
        left = heads_left_after(it);
        if (it.run_ended && left >= 0 && left < 2) it.run_ended = 1'b0;
        return it;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Sends one beat: an optional idle gap with valid low, then valid held with a
    // steady payload until the block accepts it. Valid is left high so that a
    // back-to-back beat never lowers and raises it within one time step.
    task automatic push_record(input t_item it);
        int gap;
        gap = fast_feed ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_source    <= it.source;
        i_key       <= it.key;
        i_payload   <= it.payload;
        i_run_ended <= it.run_ended;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
        if (merge_step(it)) beats_used++;
    endtask

    // Holds the input channel off until every expected record has come out and
    // any beats that cause no result have had time to pass through.
    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (emitted_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ways(input logic [CFG_W-1:0] v);
        settle_block();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        ways_reg = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Loads the heads with seven active runs. A record from the inactive run and
    // a repeated first record are both ignored, one run ends before it starts, and
    // the keys and payloads take their extreme values. The last head completes
    // the load and the smallest key comes straight out.
    task automatic test_loading();
        set_ways(CFG_W'(7));
        push_record(rec(7, 32'sd5, 64'h1, 1'b0));
        push_record(rec(0, KEY_LOWEST, '0, 1'b0));
        push_record(rec(0, 32'sd1, PAY_ONES, 1'b0));
        push_record(rec(1, KEY_HIGHEST, PAY_ONES, 1'b0));
        push_record(rec(2, KEY_HIGHEST, 64'h5555_5555_5555_5555, 1'b0));
        push_record(rec(3, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0));
        push_record(rec(4, 32'sd0, 64'h0123_4567_89ab_cdef, 1'b0));
        push_record(rec(5, 32'sd100, 64'hfedc_ba98_7654_3210, 1'b0));
        push_record(rec(6, $urandom, {$urandom, $urandom}, 1'b1));
    endtask

    // Merging rules: a refill from the wrong run is dropped, the largest key is
    // an ordinary key, and equal keys go to the lowest run.
    task automatic test_merge_rules();
        push_record(rec(3, 32'sd7, 64'h7, 1'b0));
        push_record(rec(0, KEY_HIGHEST, 64'h10, 1'b0));
        push_record(rec(3, KEY_HIGHEST, 64'h13, 1'b0));
        push_record(rec(4, KEY_HIGHEST, 64'h14, 1'b0));
        push_record(rec(5, KEY_HIGHEST, 64'h15, 1'b0));
        push_record(rec(0, KEY_HIGHEST, 64'h20, 1'b0));
        push_record(rec(0, -32'sd100, 64'h30, 1'b0));
    endtask

    // Register values outside 1 .. 8: zero acts as one, values above eight
    // saturate, and raising the count mid-merge exposes a run with no head.
    task automatic test_register_range();
        logic [CFG_W-1:0] probe [5] = '{CFG_W'(15), CFG_W'(0), CFG_W'(1), CFG_W'(9), CFG_W'(2)};
        foreach (probe[i]) begin
            set_ways(probe[i]);
            repeat (5) push_record(make_record());
        end
    endtask

    // Phases of random traffic, each with its own register setting and its own
    // pacing on both channels; some phases run without any idle cycles.
    task automatic test_random_merge();
        int start;
        int batch;
        logic [CFG_W-1:0] v;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            v = CFG_W'($urandom_range(0, 15));
            // Mostly keep the awaited run active; now and then it is switched off
            // and the whole phase should be ignored.
            if (ways_in_use(v) <= wait_src && $urandom_range(0, 7) != 0)
                v = CFG_W'($urandom_range(wait_src + 1, WAY_CAP));
            set_ways(v);
            fast_feed  = ($urandom_range(0, 3) == 0);
            fast_drain = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(20, 80);
            repeat (batch) push_record(make_record());
        end
        fast_feed  = 1'b0;
        fast_drain = 1'b0;
    endtask

    // Ends every run in turn until the block reports done, then checks that
    // further beats are all ignored.
    task automatic test_drain_to_done();
        t_item it;
        set_ways(CFG_W'(8));
        while (!merge_over) begin
            it           = make_record();
            it.source    = IDX_W'(wait_src);
            it.run_ended = 1'b1;
            push_record(it);
        end
        push_record(rec(0, 32'sd1, 64'h1, 1'b0));
        repeat (5) push_record(make_record());
    endtask

    // ------------------------------------------------------------------------
    // Clock, result pacing, checking and the cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls after each result for a freshly drawn number of cycles, or not at all in fast-drain phases.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_emitted want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            hold_cycles = fast_drain ? 0 : $urandom_range(0, MAX_GAP);
            if (emitted_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result key %0d source %0d done %b",
                                        o_out_key, o_out_source, o_all_done));
            end else begin
                want = emitted_due.pop_front();
                if (o_out_key !== want.key)
                    flag_mismatch($sformatf("key %0d, expected %0d", o_out_key, want.key));
                if (o_out_payload !== want.payload)
                    flag_mismatch($sformatf("payload %h, expected %h",
                                            o_out_payload, want.payload));
                if (o_out_source !== want.source)
                    flag_mismatch($sformatf("source %0d, expected %0d",
                                            o_out_source, want.source));
                if (o_all_done !== want.done)
                    flag_mismatch($sformatf("done flag %b, expected %b",
                                            o_all_done, want.done));
                if (want.done) done_seen++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        int waited;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_source    = '0;
        i_key       = '0;
        i_payload   = '0;
        i_run_ended = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_loading();
        test_merge_rules();
        test_register_range();
        test_random_merge();
        test_drain_to_done();

        @(negedge i_clk);
        i_valid <= 1'b0;
        waited = 0;
        while (emitted_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (emitted_due.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", emitted_due.size()));

        $display("summary: %0d beats sent, %0d acted on, %0d results checked, %0d done",
                 beats_sent, beats_used, results_seen, done_seen);
        $display("summary: %0d register writes, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
